// ----- hw/rtl/rfd_pkg.sv -----
// rfd_pkg: types, codes and the nibble code table for the manchester deframer
// no dependencies; imported by every module of the deframer

package rfd_pkg;

    localparam int RxByteW   = 8;
    localparam int SyncWordW = 24;
    localparam int WindowW   = 32;
    localparam int CountW    = 8;
    localparam int ErrW      = 3;
    localparam int CfgIndexW = 8;
    localparam int CfgDataW  = 24;

    localparam logic [SyncWordW-1:0] SyncWordRst     = 24'h335553;
    localparam logic [RxByteW-1:0]   TrailerCodeRst  = 8'h35;
    localparam logic [RxByteW-1:0]   LostSyncCodeRst = 8'hFF;
    localparam logic [CountW-1:0]    RawCapacityRst  = 8'hFF;

    localparam logic [RxByteW-1:0] ByteZero = 8'h00;
    localparam logic [RxByteW-1:0] ByteOnes = 8'hFF;
    localparam logic [3:0]         NibBad   = 4'hF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYNC = 2'd1,
        PH_MSG  = 2'd2,
        PH_RSVD = 2'd3
    } phase_t;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE = 3'd0,
        ERR_CLSN = 3'd1,
        ERR_SYNC = 3'd2,
        ERR_MANC = 3'd3,
        ERR_OVER = 3'd4
    } err_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_SYNC_WORD      = 8'd0,
        CFG_TRAILER_CODE   = 8'd1,
        CFG_LOST_SYNC_CODE = 8'd2,
        CFG_RAW_CAPACITY   = 8'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SyncWordW-1:0] sync_word;
        logic [RxByteW-1:0]   trailer_code;
        logic [RxByteW-1:0]   lost_sync_code;
        logic [CountW-1:0]    raw_capacity;
    } cfg_t;

    typedef struct packed {
        phase_t               phase;
        logic [WindowW-1:0]   window;
        logic [CountW-1:0]    count;
        logic                 toggle;
        logic [RxByteW-1:0]   partial;
    } frame_state_t;

    typedef struct packed {
        logic               byte_valid;
        logic [RxByteW-1:0] decoded_byte;
        logic               frame_end;
        err_t               error_code;
        logic [CountW-1:0]  raw_count;
        logic               in_frame;
    } result_t;

    // 4-bit code to 2 data bits, NibBad for codes that are not valid
    function automatic logic [3:0] nib_decode(input logic [3:0] code);
        logic [3:0] val;
        case (code)
            4'h5:    val = 4'h3;
            4'h6:    val = 4'h2;
            4'h9:    val = 4'h1;
            4'hA:    val = 4'h0;
            default: val = NibBad;
        endcase
        return val;
    endfunction

endpackage

// ----- hw/rtl/rfd_cfg.sv -----
// rfd_cfg: configuration registers of the deframer, written through a plain write port
// depends on rfd_pkg

module rfd_cfg import rfd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_word      <= SyncWordRst;
            cfg_reg.trailer_code   <= TrailerCodeRst;
            cfg_reg.lost_sync_code <= LostSyncCodeRst;
            cfg_reg.raw_capacity   <= RawCapacityRst;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SYNC_WORD:      cfg_reg.sync_word      <= cfg_wdata[SyncWordW-1:0];
                CFG_TRAILER_CODE:   cfg_reg.trailer_code   <= cfg_wdata[RxByteW-1:0];
                CFG_LOST_SYNC_CODE: cfg_reg.lost_sync_code <= cfg_wdata[RxByteW-1:0];
                CFG_RAW_CAPACITY:   cfg_reg.raw_capacity   <= cfg_wdata[CountW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/rfd_step.sv -----
// rfd_step: per-byte deframing logic, next frame state and result from one raw byte
// depends on rfd_pkg

module rfd_step import rfd_pkg::*; (
    input  frame_state_t       cur,
    input  cfg_t               cfg,
    input  logic [RxByteW-1:0] rx_byte,
    output frame_state_t       nxt,
    output result_t            res
);

    logic [WindowW-1:0] shifted;
    logic [WindowW-1:0] merged;
    logic [3:0]         hi;
    logic [3:0]         lo;
    logic               frame_end;
    err_t               err;
    logic               byte_valid;
    logic [RxByteW-1:0] dbyte;
    frame_state_t       upd;

    assign shifted = {cur.window[WindowW-9:0], 8'h00};
    assign merged  = {cur.window[WindowW-9:0], rx_byte};
    assign hi      = nib_decode(rx_byte[7:4]);
    assign lo      = nib_decode(rx_byte[3:0]);

    always_comb begin
        upd        = cur;
        frame_end  = 1'b0;
        err        = ERR_NONE;
        byte_valid = 1'b0;
        dbyte      = '0;
        case (cur.phase)
            PH_IDLE: begin
                upd.window = {{(WindowW-RxByteW){1'b0}}, rx_byte};
                if (rx_byte == cfg.sync_word[SyncWordW-1 -: RxByteW]) begin
                    upd.phase = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (rx_byte == ByteZero || rx_byte == ByteOnes
                        || shifted[WindowW-1 -: 8] != 8'h00) begin
                    upd.phase  = PH_IDLE;
                    upd.window = shifted;
                end else begin
                    upd.window = merged;
                    if (merged == {8'h00, cfg.sync_word}) begin
                        upd.phase   = PH_MSG;
                        upd.count   = '0;
                        upd.toggle  = 1'b0;
                        upd.partial = '0;
                    end
                end
            end
            PH_MSG: begin
                if (rx_byte == ByteZero) begin
                    frame_end = 1'b1;
                    err       = ERR_CLSN;
                end else if (rx_byte == cfg.lost_sync_code) begin
                    frame_end = 1'b1;
                    err       = ERR_SYNC;
                end else if (rx_byte == cfg.trailer_code) begin
                    frame_end = 1'b1;
                end else begin
                    upd.count = cur.count + CountW'(1);
                    if (hi == NibBad || lo == NibBad) begin
                        frame_end = 1'b1;
                        err       = ERR_MANC;
                    end else begin
                        upd.partial = {cur.partial[3:0], hi[1:0], lo[1:0]};
                        upd.toggle  = ~cur.toggle;
                        if (cur.toggle) begin
                            byte_valid = 1'b1;
                            dbyte      = upd.partial;
                        end
                    end
                end
            end
            default: begin
                upd.phase = PH_IDLE;
            end
        endcase
        // overrun once the stored count reaches capacity
        if (upd.phase == PH_MSG && !frame_end && upd.count >= cfg.raw_capacity) begin
            frame_end = 1'b1;
            err       = ERR_OVER;
        end
    end

    always_comb begin
        res.byte_valid   = byte_valid;
        res.decoded_byte = dbyte;
        res.frame_end    = frame_end;
        res.error_code   = err;
        res.raw_count    = (upd.phase == PH_MSG) ? upd.count : '0;
        if (frame_end) begin
            nxt.phase   = PH_IDLE;
            nxt.window  = '0;
            nxt.count   = '0;
            nxt.toggle  = 1'b0;
            nxt.partial = '0;
        end else begin
            nxt = upd;
        end
        res.in_frame = (nxt.phase == PH_MSG);
    end

endmodule

// ----- hw/rtl/radio_frame_rx_manchester_deframer_core.sv -----
// radio_frame_rx_manchester_deframer_core: top level of the receive deframer
// depends on rfd_pkg, rfd_cfg and rfd_step

// Takes one raw radio byte per request and returns one result per byte. A byte is
// held in an input register, run through the combinational deframing logic and
// lands in the result register, so a byte is taken every cycle while results are
// taken; the result is seen only once the byte has left the input register. The frame
// state (phase, sync window, count, nibble toggle, partial byte) advances only as
// a byte moves into the result register. Write configuration only while no
// request is in flight.

module radio_frame_rx_manchester_deframer_core import rfd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [RxByteW-1:0]   s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_byte_valid,
    output logic [RxByteW-1:0]   m_decoded_byte,
    output logic                 m_frame_end,
    output logic [ErrW-1:0]      m_error_code,
    output logic [CountW-1:0]    m_raw_count,
    output logic                 m_in_frame
);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [RxByteW-1:0] in_byte_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    frame_state_t       state_reg;
    frame_state_t       state_next;
    result_t            res;
    logic               advance;

    rfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rfd_step u_step (
        .cur     (state_reg),
        .cfg     (cfg),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (res)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase   <= PH_IDLE;
            state_reg.window  <= '0;
            state_reg.count   <= '0;
            state_reg.toggle  <= 1'b0;
            state_reg.partial <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_decoded_byte = out_reg.decoded_byte;
    assign m_frame_end    = out_reg.frame_end;
    assign m_error_code   = out_reg.error_code;
    assign m_raw_count    = out_reg.raw_count;
    assign m_in_frame     = out_reg.in_frame;

endmodule
